// ===== sv/multi_channel_rx_ring_buffer_defines.svh =====
// Assertion macros for the multi-channel receive ring buffer.
// Used by multi_channel_rx_ring_buffer.sv; expects clk and arst_n in scope.
`ifndef MULTI_CHANNEL_RX_RING_BUFFER_DEFINES_SVH
`define MULTI_CHANNEL_RX_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MCRB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define MCRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mcrb_pkg.sv =====
// Package for the multi-channel receive ring buffer: sizes, derived widths,
// operation codes. No dependencies.
`default_nettype none

package mcrb_pkg;

	// Buffer geometry
	localparam int BUFFER_DEPTH = 64;
	localparam int CHANNELS     = 4;

	// Fixed field widths
	localparam int KIND_W  = 2;
	localparam int CHAN_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int WANT_W  = 7;
	localparam int FILL_OUT_W = 7;
	localparam int ENABLE_W   = 4;

	// Derived widths
	localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W     = $clog2(BUFFER_DEPTH);
	localparam int FILL_W    = PTR_W + 1;
	localparam int CMP_W     = (FILL_W > WANT_W) ? FILL_W : WANT_W;
	localparam int MEM_DEPTH = CHANNELS * BUFFER_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Operation codes
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH   = 2'd0,
		KIND_POP    = 2'd1,
		KIND_FLUSH  = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef logic [PTR_W-1:0] ptr_t;

endpackage

`default_nettype wire

// ===== sv/multi_channel_rx_ring_buffer.sv =====
// A word accepted into the input register moves on into the output register
// as soon as that register is empty or its result is being taken.
// Throughput: one word per cycle while the output is not stalled; each word does
// at most one store write or read on the single byte store, plus any index updates.
// Reset: indexes, wrap flags, enables and valids clear at once; the byte store
// is not cleared, so no clearing pass is needed and words are taken right away.
// Holds the whole block; depends on mcrb_pkg and the assertion macro header.
`default_nettype none
`include "multi_channel_rx_ring_buffer_defines.svh"

module multi_channel_rx_ring_buffer
	import mcrb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_wr_en,
	input  wire logic [ENABLE_W-1:0]   cfg_wr_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [CHAN_W-1:0]     channel,
	input  wire logic [BYTE_W-1:0]     rx_byte,
	input  wire logic [WANT_W-1:0]     wanted_count,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       read_valid,
	output logic [BYTE_W-1:0]          read_byte,
	output logic [FILL_OUT_W-1:0]      fill_count,
	output logic                       enough_bytes,
	output logic                       byte_dropped,
	output logic                       channel_error
);

	// Configuration register
	logic [ENABLE_W-1:0] chan_en_q;

	// Per-channel ring state
	ptr_t wr_pos_q [CHANNELS];
	ptr_t rd_pos_q [CHANNELS];
	logic [CHANNELS-1:0] wrap_q;

	// Byte store
	logic [BYTE_W-1:0] mem [MEM_DEPTH];

	// Input register
	logic                valid_s1;
	kind_t               kind_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic [BYTE_W-1:0]   rx_byte_s1;
	logic [WANT_W-1:0]   want_s1;

	// Result register
	logic                valid_s2;
	logic                read_valid_s2;
	logic [BYTE_W-1:0]   read_byte_s2;
	logic [FILL_OUT_W-1:0] fill_s2;
	logic                enough_s2;
	logic                dropped_s2;
	logic                error_s2;

	// Processing signals
	logic                adv_s1;
	logic [CH_IDX_W-1:0] ch_idx;
	logic                ch_ok;
	ptr_t                cur_wr;
	ptr_t                cur_rd;
	logic                cur_wrap;
	ptr_t                wr_next;
	ptr_t                rd_next;
	logic [FILL_W-1:0]   fill;
	logic                enough;
	logic                is_full;
	logic                not_empty;
	logic                push_ok;
	logic                pop_ok;
	logic                flush_op;
	logic                push_full;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;

	// Handshake: the input word moves on when the result register is free
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Channel selection and current state
	always_comb begin
		ch_idx   = CH_IDX_W'(chan_s1);
		ch_ok    = (int'(chan_s1) < CHANNELS) && chan_en_q[chan_s1];
		cur_wr   = wr_pos_q[ch_idx];
		cur_rd   = rd_pos_q[ch_idx];
		cur_wrap = wrap_q[ch_idx];
	end

	// Fill count and status, taken before the operation
	always_comb begin
		fill      = {1'b0, cur_wr} + (cur_wrap ? FILL_W'(BUFFER_DEPTH) : '0)
			- {1'b0, cur_rd};
		enough    = CMP_W'(fill) >= CMP_W'(want_s1);
		is_full   = cur_wrap && (cur_rd == cur_wr);
		not_empty = cur_wrap || (cur_rd < cur_wr);
		wr_next   = (cur_wr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : cur_wr + 1'b1;
		rd_next   = (cur_rd == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : cur_rd + 1'b1;
	end

	// Operation decode
	always_comb begin
		push_ok   = 1'b0;
		push_full = 1'b0;
		pop_ok    = 1'b0;
		flush_op  = 1'b0;
		if (ch_ok) begin
			case (kind_s1)
				KIND_PUSH: begin
					push_ok   = !is_full;
					push_full = is_full;
				end
				KIND_POP: begin
					pop_ok = not_empty;
				end
				KIND_FLUSH: begin
					flush_op = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Store addresses: channel base plus position
	assign wr_addr = ADDR_W'(ch_idx) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(cur_wr);
	assign rd_addr = ADDR_W'(ch_idx) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(cur_rd);

	// Configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_en_q <= '0;
		end else if (cfg_wr_en) begin
			chan_en_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1    <= kind_t'(kind);
			chan_s1    <= channel;
			rx_byte_s1 <= rx_byte;
			want_s1    <= wanted_count;
		end
	end

	// Ring index update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wr_pos_q[i] <= '0;
				rd_pos_q[i] <= '0;
			end
			wrap_q <= '0;
		end else if (adv_s1) begin
			if (push_ok) begin
				wr_pos_q[ch_idx] <= wr_next;
				if (wr_next == '0) begin
					wrap_q[ch_idx] <= 1'b1;
				end
			end
			if (pop_ok) begin
				rd_pos_q[ch_idx] <= rd_next;
				if (rd_next == '0) begin
					wrap_q[ch_idx] <= 1'b0;
				end
			end
			if (flush_op) begin
				rd_pos_q[ch_idx] <= cur_wr;
				wrap_q[ch_idx]   <= 1'b0;
			end
		end
	end

	// Byte store: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (adv_s1 && push_ok) begin
			mem[wr_addr] <= rx_byte_s1;
		end
		if (adv_s1) begin
			read_byte_s2 <= pop_ok ? mem[rd_addr] : '0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_valid_s2 <= pop_ok;
			fill_s2       <= ch_ok ? FILL_OUT_W'(fill) : '0;
			enough_s2     <= ch_ok && enough;
			dropped_s2    <= push_full;
			error_s2      <= !ch_ok;
		end
	end

	assign out_valid     = valid_s2;
	assign read_valid    = read_valid_s2;
	assign read_byte     = read_byte_s2;
	assign fill_count    = fill_s2;
	assign enough_bytes  = enough_s2;
	assign byte_dropped  = dropped_s2;
	assign channel_error = error_s2;

	// Checks
	`MCRB_ASSERT_NEXT(a_pop_returns_byte, adv_s1 && pop_ok,
		out_valid && read_valid && !channel_error, "pop with data gave no byte")
	`MCRB_ASSERT_NOW(a_error_clean, out_valid && channel_error,
		!read_valid && !byte_dropped && !enough_bytes && fill_count == '0,
		"disabled channel result carries data")
	`MCRB_ASSERT_NOW(a_stall_needs_word, !valid_s1, !in_stall,
		"input stalled with empty input register")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for the four-channel receive ring buffer. It drives push,
// pop, flush and status words with random idling and checks every result word.
// Depends on mcrb_pkg and multi_channel_rx_ring_buffer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mcrb_pkg::*;

	localparam int HOLD_CYCLES = 200;

	// one operation word and the result word it produces
	typedef struct {
		kind_t                 kind;
		logic [CHAN_W-1:0]     chan;
		logic [BYTE_W-1:0]     data;
		logic [WANT_W-1:0]     want;
	} ring_op_t;

	typedef struct {
		logic                  rd_vld;
		logic [BYTE_W-1:0]     rd_byte;
		logic [FILL_OUT_W-1:0] fill;
		logic                  enough;
		logic                  dropped;
		logic                  err;
	} ring_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [ENABLE_W-1:0]   cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [KIND_W-1:0]     kind;
	logic [CHAN_W-1:0]     channel;
	logic [BYTE_W-1:0]     rx_byte;
	logic [WANT_W-1:0]     wanted_count;
	logic                  out_valid;
	logic                  out_stall;
	logic                  read_valid;
	logic [BYTE_W-1:0]     read_byte;
	logic [FILL_OUT_W-1:0] fill_count;
	logic                  enough_bytes;
	logic                  byte_dropped;
	logic                  channel_error;

	// predictor copy of the ring state
	logic [ENABLE_W-1:0]   en_mask;
	ptr_t                  wr_ptr [CHANNELS];
	ptr_t                  rd_ptr [CHANNELS];
	logic                  wrapped [CHANNELS];
	logic [BYTE_W-1:0]     byte_mem [CHANNELS][BUFFER_DEPTH];

	ring_op_t      op_queue [$];
	ring_report_t  ring_reports_q [$];

	int tx_gap = 0;
	int rx_wait = 0;
	int tx_idle_max = 0;
	int rx_idle_max = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int fail_count = 0;
	int ops_queued = 0;
	int ops_accepted = 0;
	int settings_used = 0;
	int drops_seen = 0;
	int pops_seen = 0;
	int disabled_hits = 0;

	multi_channel_rx_ring_buffer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.channel       (channel),
		.rx_byte       (rx_byte),
		.wanted_count  (wanted_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_valid    (read_valid),
		.read_byte     (read_byte),
		.fill_count    (fill_count),
		.enough_bytes  (enough_bytes),
		.byte_dropped  (byte_dropped),
		.channel_error (channel_error)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected result of one word; updates the predictor state
	function automatic ring_report_t predict_ring_op(ring_op_t op);
		ring_report_t rep;
		int c;
		logic [FILL_W-1:0] held;
		rep = '{default: '0};
		c = op.chan;
		if (c >= CHANNELS || !en_mask[c]) begin
			rep.err = 1'b1;
			disabled_hits++;
			return rep;
		end
		// wrap flag acts as the top bit of the write index
		held = {wrapped[c], wr_ptr[c]} - {1'b0, rd_ptr[c]};
		rep.fill = FILL_OUT_W'(held);
		rep.enough = (held >= op.want);
		case (op.kind)
			KIND_PUSH: begin
				if (wrapped[c] && rd_ptr[c] == wr_ptr[c]) begin
					rep.dropped = 1'b1;
					drops_seen++;
				end else begin
					byte_mem[c][wr_ptr[c]] = op.data;
					if (wr_ptr[c] == ptr_t'(BUFFER_DEPTH - 1)) begin
						wr_ptr[c] = '0;
						wrapped[c] = 1'b1;
					end else begin
						wr_ptr[c] = wr_ptr[c] + 1'b1;
					end
				end
			end
			KIND_POP: begin
				if (wrapped[c] || rd_ptr[c] < wr_ptr[c]) begin
					rep.rd_vld = 1'b1;
					rep.rd_byte = byte_mem[c][rd_ptr[c]];
					pops_seen++;
					if (rd_ptr[c] == ptr_t'(BUFFER_DEPTH - 1)) begin
						rd_ptr[c] = '0;
						wrapped[c] = 1'b0;
					end else begin
						rd_ptr[c] = rd_ptr[c] + 1'b1;
					end
				end
			end
			KIND_FLUSH: begin
				rd_ptr[c] = wr_ptr[c];
				wrapped[c] = 1'b0;
			end
			default: ;
		endcase
		return rep;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got);
		if (got !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, got);
			fail_count++;
		end
	endfunction

	// driver: next word after a random gap, held while stalled
	always @(posedge clk) begin : drive_ops
		ring_op_t nxt;
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid)
				tx_gap = $urandom_range(0, tx_idle_max);
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (op_queue.size() != 0) begin
				nxt = op_queue.pop_front();
				in_valid <= 1'b1;
				kind <= nxt.kind;
				channel <= nxt.chan;
				rx_byte <= nxt.data;
				wanted_count <= nxt.want;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input monitor: predict each accepted word
	always @(posedge clk) begin : predict_accepted
		ring_op_t op;
		if (arst_n && in_valid && !in_stall) begin
			op.kind = kind_t'(kind);
			op.chan = channel;
			op.data = rx_byte;
			op.want = wanted_count;
			ring_reports_q.push_back(predict_ring_op(op));
			ops_accepted++;
		end
	end

	// output monitor and receiver stall
	always @(posedge clk) begin : check_reports
		ring_report_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (ring_reports_q.size() == 0) begin
				$error("result word with no operation outstanding");
				fail_count++;
			end else begin
				exp_r = ring_reports_q.pop_front();
				check_field("read_valid", 8'(exp_r.rd_vld), 8'(read_valid));
				check_field("read_byte", exp_r.rd_byte, read_byte);
				check_field("fill_count", 8'(exp_r.fill), 8'(fill_count));
				check_field("enough_bytes", 8'(exp_r.enough), 8'(enough_bytes));
				check_field("byte_dropped", 8'(exp_r.dropped), 8'(byte_dropped));
				check_field("channel_error", 8'(exp_r.err), 8'(channel_error));
			end
			rx_wait = $urandom_range(0, rx_idle_max);
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		// long hold-off on request, to back the block up
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0) || (rx_wait > 0);
	end

	task automatic queue_op(kind_t k, int ch, int d, int w);
		ring_op_t op;
		op.kind = k;
		op.chan = CHAN_W'(ch);
		op.data = BYTE_W'(d);
		op.want = WANT_W'(w);
		op_queue.push_back(op);
		ops_queued++;
	endtask

	// wanted count: half spread over the full range, half near real fill levels
	function automatic int rand_want();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 127);
		return $urandom_range(0, BUFFER_DEPTH + 2);
	endfunction

	// mostly enabled channels, sometimes any
	function automatic int pick_channel();
		int c;
		if (en_mask == '0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, CHANNELS - 1);
		do
			c = $urandom_range(0, CHANNELS - 1);
		while (!en_mask[c]);
		return c;
	endfunction

	// sampled mid-cycle so the driver and monitors have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (op_queue.size() != 0 || in_valid || ring_reports_q.size() != 0);
	endtask

	task automatic write_enable(logic [ENABLE_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		en_mask = value;
		settings_used++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// bursts of pushes and pops, mixed traffic, flushes and raw noise
	task automatic random_traffic(int n_ops);
		int start;
		int ch;
		int len;
		kind_t k;
		start = ops_queued;
		while (ops_queued - start < n_ops) begin
			ch = pick_channel();
			len = $urandom_range(1, BUFFER_DEPTH + 6);
			case ($urandom_range(0, 9))
				0, 1, 2: repeat (len) queue_op(KIND_PUSH, ch, $urandom_range(0, 255), rand_want());
				3, 4: repeat (len) queue_op(KIND_POP, ch, $urandom_range(0, 255), rand_want());
				5, 6, 7: begin
					repeat (24) begin
						if ($urandom_range(0, 19) < 11)
							k = KIND_PUSH;
						else if ($urandom_range(0, 7) == 0)
							k = KIND_STATUS;
						else
							k = KIND_POP;
						queue_op(k, ch, $urandom_range(0, 255), rand_want());
					end
				end
				8: begin
					queue_op(KIND_FLUSH, ch, $urandom_range(0, 255), rand_want());
					queue_op(KIND_STATUS, ch, $urandom_range(0, 255), rand_want());
				end
				default: begin
					repeat (8) queue_op(kind_t'($urandom_range(0, 3)), $urandom_range(0, 3),
						$urandom_range(0, 255), $urandom_range(0, 127));
				end
			endcase
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		kind = KIND_STATUS;
		channel = '0;
		rx_byte = '0;
		wanted_count = '0;
		out_stall = 1'b0;
		en_mask = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			wr_ptr[c] = '0;
			rd_ptr[c] = '0;
			wrapped[c] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// every operation on a channel that is still disabled
		queue_op(KIND_PUSH, 0, 8'hAA, 0);
		queue_op(KIND_POP, 3, 8'h55, 127);
		queue_op(KIND_FLUSH, 1, 8'h00, 0);
		queue_op(KIND_STATUS, 2, 8'hFF, 64);
		write_enable(4'hF);

		// empty pop, byte extremes, count threshold, flush, drain
		queue_op(KIND_STATUS, 0, 8'h00, 0);
		queue_op(KIND_STATUS, 0, 8'h00, 1);
		queue_op(KIND_POP, 0, 8'h00, 0);
		queue_op(KIND_PUSH, 0, 8'h00, 127);
		queue_op(KIND_PUSH, 0, 8'hFF, 0);
		queue_op(KIND_PUSH, 1, 8'h5A, 64);
		queue_op(KIND_STATUS, 0, 8'h00, 2);
		queue_op(KIND_STATUS, 0, 8'h00, 3);
		queue_op(KIND_POP, 0, 8'h00, 0);
		queue_op(KIND_POP, 0, 8'h00, 0);
		queue_op(KIND_POP, 0, 8'h00, 0);
		queue_op(KIND_PUSH, 2, 8'h81, 0);
		queue_op(KIND_PUSH, 2, 8'h7E, 0);
		queue_op(KIND_FLUSH, 2, 8'h00, 2);
		queue_op(KIND_POP, 2, 8'h00, 0);
		queue_op(KIND_STATUS, 2, 8'h00, 0);
		queue_op(KIND_PUSH, 3, 8'hC3, 1);
		queue_op(KIND_POP, 1, 8'h00, 0);
		queue_op(KIND_POP, 3, 8'h00, 127);

		// fill one channel past full, then drain past empty: both indexes wrap
		tx_idle_max = 6;
		rx_idle_max = 6;
		repeat (BUFFER_DEPTH + 2) queue_op(KIND_PUSH, 1, $urandom_range(0, 255), rand_want());
		repeat (BUFFER_DEPTH + 2) queue_op(KIND_POP, 1, $urandom_range(0, 255), rand_want());
		random_traffic(300);

		// receiver holds off while the sender keeps offering words
		wait_idle();
		tx_idle_max = 0;
		rx_idle_max = 0;
		random_traffic(150);
		hold_token++;

		write_enable(4'h5);
		tx_idle_max = 6;
		rx_idle_max = 0;
		random_traffic(250);

		write_enable(4'hA);
		tx_idle_max = 0;
		rx_idle_max = 6;
		random_traffic(250);

		write_enable(4'h0);
		random_traffic(40);

		write_enable(ENABLE_W'($urandom_range(1, 14)));
		tx_idle_max = 6;
		rx_idle_max = 6;
		random_traffic(300);

		write_enable(4'hF);
		tx_idle_max = 0;
		rx_idle_max = 0;
		random_traffic(200);
		tx_idle_max = 3;
		rx_idle_max = 3;
		random_traffic(200);

		// drain and let the pipeline settle
		wait_idle();
		repeat (4) @(posedge clk);
		if (ring_reports_q.size() != 0) begin
			$error("%0d result words never arrived", ring_reports_q.size());
			fail_count++;
		end
		$display("Checked %0d ring operations under %0d enable settings.",
			ops_accepted, settings_used);
		$display("Pushes dropped when full: %0d, bytes popped: %0d, disabled words: %0d.",
			drops_seen, pops_seen, disabled_hits);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mcrb_pkg.sv
sv/multi_channel_rx_ring_buffer.sv
dv/tb_top.sv
